// ===== hdl/tty_output_postprocessor_unit_macros.svh =====
// Assertion macros for the RTL of the output post-processor.
`ifndef TTY_OUTPUT_POSTPROCESSOR_UNIT_MACROS_SVH
`define TTY_OUTPUT_POSTPROCESSOR_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TTYOP_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TTYOP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/ttyop_pkg.sv =====
package ttyop_pkg;

   localparam int ByteWidth = 8;
   localparam int ColWidth  = 16;
   localparam int DvdWidth  = ColWidth + 1;
   localparam int CntWidth  = $clog2(DvdWidth + 1);
   localparam int AddrWidth = 5;
   localparam int DataWidth = 32;

   localparam logic [ByteWidth-1:0] ChNl = 8'h0A;
   localparam logic [ByteWidth-1:0] ChCr = 8'h0D;
   localparam logic [ByteWidth-1:0] ChBs = 8'h08;

   localparam logic [ColWidth-1:0] ScreenColsReset = 16'd80;

   typedef enum logic [2:0] {
      RegPostEnable = 3'd0,
      RegNlToCrnl   = 3'd1,
      RegCrToNl     = 3'd2,
      RegNoCrAtCol0 = 3'd3,
      RegNlResetsCol = 3'd4,
      RegScreenCols = 3'd5
   } reg_idx_type;

   typedef struct packed {
      logic                post_enable;
      logic                nl_to_crnl;
      logic                cr_to_nl;
      logic                no_cr_at_col0;
      logic                nl_resets_col;
      logic [ColWidth-1:0] screen_cols;
   } cfg_type;

   // Controller to datapath
   typedef struct packed {
      logic plan_load;
      logic fast_emit;
      logic div_start;
      logic div_commit;
      logic late_emit;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic plan_empty;
      logic needs_div;
      logic div_done;
      logic out_free;
      logic last;
   } sts_type;

   typedef enum logic [3:0] {
      StIdle = 4'b0001,
      StCol  = 4'b0010,
      StDiv  = 4'b0100,
      StPush = 4'b1000
   } state_type;

endpackage

// ===== hdl/ttyop_csr.sv =====
module ttyop_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [ttyop_pkg::AddrWidth-1:0] csr_paddr,
   input  logic [ttyop_pkg::DataWidth-1:0] csr_pwdata,
   output logic [ttyop_pkg::DataWidth-1:0] csr_prdata,
   output logic                           csr_pready,
   output ttyop_pkg::cfg_type             cfg
);
   import ttyop_pkg::*;

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   reg_idx_type idx;
   logic        wr_en;

   assign idx        = reg_idx_type'(csr_paddr[AddrWidth-1:2]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            RegPostEnable:  cfg_in.post_enable   = csr_pwdata[0];
            RegNlToCrnl:    cfg_in.nl_to_crnl    = csr_pwdata[0];
            RegCrToNl:      cfg_in.cr_to_nl      = csr_pwdata[0];
            RegNoCrAtCol0:  cfg_in.no_cr_at_col0 = csr_pwdata[0];
            RegNlResetsCol: cfg_in.nl_resets_col = csr_pwdata[0];
            RegScreenCols:  cfg_in.screen_cols   = csr_pwdata[ColWidth-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         RegPostEnable:  csr_prdata = DataWidth'(cfg_ff.post_enable);
         RegNlToCrnl:    csr_prdata = DataWidth'(cfg_ff.nl_to_crnl);
         RegCrToNl:      csr_prdata = DataWidth'(cfg_ff.cr_to_nl);
         RegNoCrAtCol0:  csr_prdata = DataWidth'(cfg_ff.no_cr_at_col0);
         RegNlResetsCol: csr_prdata = DataWidth'(cfg_ff.nl_resets_col);
         RegScreenCols:  csr_prdata = DataWidth'(cfg_ff.screen_cols);
         default:        csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.post_enable   <= 1'b1;
         cfg_ff.nl_to_crnl    <= 1'b1;
         cfg_ff.cr_to_nl      <= 1'b0;
         cfg_ff.no_cr_at_col0 <= 1'b0;
         cfg_ff.nl_resets_col <= 1'b0;
         cfg_ff.screen_cols   <= ScreenColsReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== hdl/ttyop_rem.sv =====
module ttyop_rem (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [ttyop_pkg::DvdWidth-1:0] dividend,
   input  logic [ttyop_pkg::ColWidth-1:0] divisor,
   output logic                          done,
   output logic [ttyop_pkg::ColWidth-1:0] remainder
);
   import ttyop_pkg::*;

   logic                busy_ff;
   logic                done_ff;
   logic [CntWidth-1:0] cnt_ff;
   logic [DvdWidth-1:0] dvd_ff;
   logic [ColWidth-1:0] rem_ff;
   logic [DvdWidth-1:0] trial;
   logic [DvdWidth-1:0] dsr_ext;
   logic [ColWidth-1:0] rem_in;

   // Restoring remainder: one dividend bit per cycle.
   assign trial   = {rem_ff, dvd_ff[DvdWidth-1]};
   assign dsr_ext = {1'b0, divisor};

   always_comb begin
      if (trial >= dsr_ext) begin
         rem_in = ColWidth'(trial - dsr_ext);
      end else begin
         rem_in = trial[ColWidth-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CntWidth'(DvdWidth);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CntWidth'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         dvd_ff <= dividend;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         dvd_ff <= {dvd_ff[DvdWidth-2:0], 1'b0};
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

// ===== hdl/ttyop_dpath.sv =====
`include "tty_output_postprocessor_unit_macros.svh"

module ttyop_dpath (
   input  logic                           clock,
   input  logic                           reset,
   input  ttyop_pkg::cfg_type             cfg,
   input  ttyop_pkg::cmd_type             cmd,
   output ttyop_pkg::sts_type             sts,
   input  logic [ttyop_pkg::ByteWidth-1:0] req_in_byte,
   input  logic                           rsp_ready,
   output logic                           rsp_valid,
   output logic [ttyop_pkg::ByteWidth-1:0] rsp_out_byte,
   output logic [ttyop_pkg::ColWidth-1:0]  rsp_column_after,
   output logic                           rsp_last_of_run
);
   import ttyop_pkg::*;

   logic [ColWidth-1:0]  column_ff;
   logic [ByteWidth-1:0] byte0_ff;
   logic [ByteWidth-1:0] byte1_ff;
   logic                 two_ff;
   logic                 idx_ff;
   logic                 rsp_valid_ff;
   logic [ByteWidth-1:0] out_byte_ff;
   logic [ColWidth-1:0]  out_col_ff;
   logic                 out_last_ff;

   logic [ByteWidth-1:0] plan_byte0;
   logic                 plan_two;
   logic                 plan_empty;
   logic [ByteWidth-1:0] cur_byte;
   logic                 cur_plain;
   logic                 last;
   logic [DvdWidth-1:0]  inc;
   logic [DvdWidth-1:0]  cols_ext;
   logic [DvdWidth-1:0]  cols_dbl;
   logic [ColWidth-1:0]  col_fast;
   logic                 needs_div;
   logic                 div_done;
   logic [ColWidth-1:0]  rem;
   logic                 emit;

   // Translation plan for the byte at the input port.
   always_comb begin
      plan_byte0 = req_in_byte;
      plan_two   = 1'b0;
      plan_empty = 1'b0;
      if (cfg.post_enable && req_in_byte == ChNl) begin
         if (cfg.nl_to_crnl) begin
            plan_byte0 = ChCr;
            plan_two   = 1'b1;
         end else begin
            plan_byte0 = ChNl;
         end
      end else if (cfg.post_enable && req_in_byte == ChCr) begin
         if (cfg.cr_to_nl) begin
            plan_byte0 = ChNl;
         end else if (cfg.no_cr_at_col0 && column_ff == '0) begin
            plan_empty = 1'b1;
         end else begin
            plan_byte0 = ChCr;
         end
      end else begin
         plan_byte0 = req_in_byte;
      end
   end

   assign cur_byte  = idx_ff ? byte1_ff : byte0_ff;
   assign last      = !two_ff || idx_ff;
   assign cur_plain = (cur_byte != ChCr) && (cur_byte != ChNl) && (cur_byte != ChBs);

   // Fast column update; a plain byte whose increment reaches twice the nonzero width needs the remainder unit.
   assign inc      = {1'b0, column_ff} + DvdWidth'(1);
   assign cols_ext = {1'b0, cfg.screen_cols};
   assign cols_dbl = {cfg.screen_cols, 1'b0};

   always_comb begin
      needs_div = 1'b0;
      if (cur_byte == ChCr) begin
         col_fast = '0;
      end else if (cur_byte == ChNl) begin
         col_fast = cfg.nl_resets_col ? '0 : column_ff;
      end else if (cur_byte == ChBs) begin
         col_fast = (column_ff == '0) ? '0 : column_ff - 1'b1;
      end else if (cfg.screen_cols == '0) begin
         col_fast = inc[ColWidth-1:0];
      end else if (inc < cols_ext) begin
         col_fast = inc[ColWidth-1:0];
      end else if (inc < cols_dbl) begin
         col_fast = ColWidth'(inc - cols_ext);
      end else begin
         needs_div = 1'b1;
         col_fast  = column_ff;
      end
   end

   ttyop_rem u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (inc),
      .divisor   (cfg.screen_cols),
      .done      (div_done),
      .remainder (rem)
   );

   assign emit = cmd.fast_emit | cmd.late_emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff    <= '0;
         two_ff       <= 1'b0;
         idx_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.fast_emit) begin
            column_ff <= col_fast;
         end else if (cmd.div_commit) begin
            column_ff <= rem;
         end
         if (cmd.plan_load) begin
            two_ff <= plan_two;
            idx_ff <= 1'b0;
         end else if (emit) begin
            idx_ff <= 1'b1;
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.plan_load) begin
         byte0_ff <= plan_byte0;
         byte1_ff <= ChNl;
      end
      if (emit) begin
         out_byte_ff <= cur_byte;
         out_last_ff <= last;
         out_col_ff  <= cmd.fast_emit ? col_fast : column_ff;
      end
   end

   assign sts.plan_empty = plan_empty;
   assign sts.needs_div  = needs_div;
   assign sts.div_done   = div_done;
   assign sts.out_free   = !rsp_valid_ff || rsp_ready;
   assign sts.last       = last;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_byte     = out_byte_ff;
   assign rsp_column_after = out_col_ff;
   assign rsp_last_of_run  = out_last_ff;

   `TTYOP_ASSERT_SAME(a_no_overwrite, clock, reset, emit, (!rsp_valid_ff || rsp_ready), "result beat overwritten before taken")
   `TTYOP_ASSERT_NEXT(a_col_in_range, clock, reset, (cmd.fast_emit && cur_plain && cfg.screen_cols != '0), (column_ff < cfg.screen_cols), "column left the screen width")
   `TTYOP_ASSERT_SAME(a_rem_in_range, clock, reset, cmd.div_commit, (div_done && rem < cfg.screen_cols), "remainder committed before done or out of range")

endmodule

// ===== hdl/ttyop_ctrl.sv =====
module ttyop_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  ttyop_pkg::sts_type sts,
   output ttyop_pkg::cmd_type cmd
);
   import ttyop_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_ready = 1'b0;
      unique case (state_ff)
         StIdle: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.plan_load = 1'b1;
               if (!sts.plan_empty) begin
                  state_in = StCol;
               end
            end
         end
         StCol: begin
            if (sts.needs_div) begin
               cmd.div_start = 1'b1;
               state_in      = StDiv;
            end else if (sts.out_free) begin
               cmd.fast_emit = 1'b1;
               state_in      = sts.last ? StIdle : StCol;
            end
         end
         StDiv: begin
            if (sts.div_done) begin
               cmd.div_commit = 1'b1;
               state_in       = StPush;
            end
         end
         StPush: begin
            if (sts.out_free) begin
               cmd.late_emit = 1'b1;
               state_in      = sts.last ? StIdle : StCol;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hdl/tty_output_postprocessor_unit.sv =====
// A result beat is offered from the output register, which the sequencer loads from the
// byte plan registers after it leaves idle; the NL of a CR NL pair follows the CR.
// A new input is taken only in idle, once every byte of the previous one has been emitted.
// A column wrap that needs a true remainder (column+1 at least twice the width) waits on
// the bit-serial remainder unit (one dividend bit per cycle, 17 bits).
// Reset: synchronous, active high; registers to defaults, column to zero, no beat held.
module tty_output_postprocessor_unit (
   input  logic                           clock,
   input  logic                           reset,
   // input channel
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [ttyop_pkg::ByteWidth-1:0] req_in_byte,
   // result channel
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [ttyop_pkg::ByteWidth-1:0] rsp_out_byte,
   output logic [ttyop_pkg::ColWidth-1:0]  rsp_column_after,
   output logic                           rsp_last_of_run,
   // configuration port
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [ttyop_pkg::AddrWidth-1:0] csr_paddr,
   input  logic [ttyop_pkg::DataWidth-1:0] csr_pwdata,
   output logic [ttyop_pkg::DataWidth-1:0] csr_prdata,
   output logic                           csr_pready
);
   import ttyop_pkg::*;

   // Output flags and screen width, one register per word address.
   cfg_type cfg;
   // Handshake between the sequencer and the datapath.
   cmd_type cmd;
   sts_type sts;

   ttyop_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Sequencer: take a beat, then step through the one or two bytes it
   // translates into, waiting on the remainder unit or the output
   // register where needed. A dropped carriage return keeps the sequencer
   // in idle without producing a beat.
   ttyop_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Datapath: translation plan, column tracking, remainder unit and the
   // output register. The output register lets a new input beat be
   // taken while the previous result still waits downstream.
   ttyop_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .cmd              (cmd),
      .sts              (sts),
      .req_in_byte      (req_in_byte),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_column_after (rsp_column_after),
      .rsp_last_of_run  (rsp_last_of_run)
   );

endmodule

// ===== tb/sv/ttyop_display_checker.sv =====
module ttyop_display_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_ready,
   input  logic [ttyop_pkg::ByteWidth-1:0]      req_in_byte,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   input  logic [ttyop_pkg::ByteWidth-1:0]      rsp_out_byte,
   input  logic [ttyop_pkg::ColWidth-1:0]       rsp_column_after,
   input  logic                                 rsp_last_of_run,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [ttyop_pkg::AddrWidth-1:0]      csr_paddr,
   input  logic [ttyop_pkg::DataWidth-1:0]      csr_pwdata,
   input  logic [ttyop_pkg::DataWidth-1:0]      csr_prdata,
   input  logic                                 csr_pready,
   output int                                   mismatch_total,
   output int                                   pending_beats
);
   import ttyop_pkg::*;

   typedef struct packed {
      logic [ByteWidth-1:0] out_byte;
      logic [ColWidth-1:0]  column_after;
      logic                 last_of_run;
   } display_beat_type;

   cfg_type              shadow_cfg;
   logic [ColWidth-1:0]  tracked_column;
   display_beat_type     display_q[$];
   int                   miss_count = 0;

   function automatic logic [ColWidth-1:0] column_after_byte(input logic [ByteWidth-1:0] b);
      logic [DvdWidth-1:0] bumped;
      logic [DvdWidth-1:0] wrapped;
      bumped = {1'b0, tracked_column} + 1'b1;
      if (b == ChCr) return '0;
      if (b == ChNl) return shadow_cfg.nl_resets_col ? '0 : tracked_column;
      if (b == ChBs) return (tracked_column != '0) ? tracked_column - 1'b1 : tracked_column;
      if (shadow_cfg.screen_cols != '0) begin
         wrapped = bumped % {1'b0, shadow_cfg.screen_cols};
         return wrapped[ColWidth-1:0];
      end
      return bumped[ColWidth-1:0];
   endfunction

   task automatic push_display_byte(input logic [ByteWidth-1:0] b);
      display_beat_type beat;
      tracked_column    = column_after_byte(b);
      beat.out_byte     = b;
      beat.column_after = tracked_column;
      beat.last_of_run  = 1'b0;
      display_q.push_back(beat);
   endtask

   task automatic translate_input(input logic [ByteWidth-1:0] c);
      int               queued_n;
      display_beat_type tail;
      queued_n = display_q.size();
      if (shadow_cfg.post_enable && c == ChNl) begin
         if (shadow_cfg.nl_to_crnl) push_display_byte(ChCr);
         push_display_byte(ChNl);
      end else if (shadow_cfg.post_enable && c == ChCr) begin
         if (shadow_cfg.cr_to_nl) begin
            push_display_byte(ChNl);
         end else if (!(shadow_cfg.no_cr_at_col0 && tracked_column == '0)) begin
            push_display_byte(ChCr);
         end
      end else begin
         push_display_byte(c);
      end
      // mark the final beat of this input's run
      if (display_q.size() > queued_n) begin
         tail = display_q.pop_back();
         tail.last_of_run = 1'b1;
         display_q.push_back(tail);
      end
   endtask

   function automatic logic [DataWidth-1:0] register_value(input logic [2:0] idx);
      case (idx)
         RegPostEnable:  return {{(DataWidth-1){1'b0}}, shadow_cfg.post_enable};
         RegNlToCrnl:    return {{(DataWidth-1){1'b0}}, shadow_cfg.nl_to_crnl};
         RegCrToNl:      return {{(DataWidth-1){1'b0}}, shadow_cfg.cr_to_nl};
         RegNoCrAtCol0:  return {{(DataWidth-1){1'b0}}, shadow_cfg.no_cr_at_col0};
         RegNlResetsCol: return {{(DataWidth-1){1'b0}}, shadow_cfg.nl_resets_col};
         RegScreenCols:  return {{(DataWidth-ColWidth){1'b0}}, shadow_cfg.screen_cols};
         default:        return '0;
      endcase
   endfunction

   task automatic write_register(input logic [2:0] idx, input logic [DataWidth-1:0] value);
      case (idx)
         RegPostEnable:  shadow_cfg.post_enable   = value[0];
         RegNlToCrnl:    shadow_cfg.nl_to_crnl    = value[0];
         RegCrToNl:      shadow_cfg.cr_to_nl      = value[0];
         RegNoCrAtCol0:  shadow_cfg.no_cr_at_col0 = value[0];
         RegNlResetsCol: shadow_cfg.nl_resets_col = value[0];
         RegScreenCols:  shadow_cfg.screen_cols   = value[ColWidth-1:0];
         default: ;
      endcase
   endtask

   task automatic compare_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (want !== got) begin
         miss_count++;
         $error("%s: expected %0h, got %0h", name, want, got);
      end
   endtask

   always @(posedge clock) begin
      display_beat_type want;
      logic [2:0]       csr_idx;
      csr_idx = csr_paddr[AddrWidth-1:2];
      if (reset) begin
         shadow_cfg.post_enable   = 1'b1;
         shadow_cfg.nl_to_crnl    = 1'b1;
         shadow_cfg.cr_to_nl      = 1'b0;
         shadow_cfg.no_cr_at_col0 = 1'b0;
         shadow_cfg.nl_resets_col = 1'b0;
         shadow_cfg.screen_cols   = ScreenColsReset;
         tracked_column           = '0;
         display_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (display_q.size() == 0) begin
               compare_field("display beat with none expected, out_byte", 32'hxxxx_xxxx,
                             32'(rsp_out_byte));
            end else begin
               want = display_q.pop_front();
               compare_field("out_byte", 32'(want.out_byte), 32'(rsp_out_byte));
               compare_field("column_after", 32'(want.column_after), 32'(rsp_column_after));
               compare_field("last_of_run", 32'(want.last_of_run), 32'(rsp_last_of_run));
            end
         end
         if (req_valid && req_ready) translate_input(req_in_byte);
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               write_register(csr_idx, csr_pwdata);
            end else if (csr_idx <= RegScreenCols) begin
               compare_field("prdata", register_value(csr_idx), csr_prdata);
            end
         end
      end
      mismatch_total <= miss_count;
      pending_beats  <= display_q.size();
   end

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;
   import ttyop_pkg::*;

   // Out-of-range register slots: writes there must leave every setting alone.
   localparam logic [2:0] RegSpareLo = 3'd6;
   localparam logic [2:0] RegSpareHi = 3'd7;

   // Quiet cycles after the last expected beat: covers a dropped CR still in
   // flight and a slow remainder with margin.
   localparam int SettleCycles = 40;
   // Bound on the slowest legal run: some 670 bytes, each with two beats behind
   // a remainder and full stalls, plus register traffic, drains and the long
   // hold-off; the limit takes it several times over.
   localparam int CycleLimit   = 200_000;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_ready;
   logic [ByteWidth-1:0]  req_in_byte = '0;
   logic                  rsp_valid;
   logic                  rsp_ready   = 1'b0;
   logic [ByteWidth-1:0]  rsp_out_byte;
   logic [ColWidth-1:0]   rsp_column_after;
   logic                  rsp_last_of_run;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [AddrWidth-1:0]  csr_paddr   = '0;
   logic [DataWidth-1:0]  csr_pwdata  = '0;
   logic [DataWidth-1:0]  csr_prdata;
   logic                  csr_pready;

   int  mismatch_total;
   int  pending_beats;
   int  cycle_count = 0;
   bit  req_idles   = 1'b0;
   bit  rsp_idles   = 1'b0;
   // Receiver hold-off, set by the stimulus and counted down by the receiver.
   int  hold_left   = 0;

   always #1 clock = ~clock;

   tty_output_postprocessor_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_in_byte      (req_in_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_column_after (rsp_column_after),
      .rsp_last_of_run  (rsp_last_of_run),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   ttyop_display_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_in_byte      (req_in_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_column_after (rsp_column_after),
      .rsp_last_of_run  (rsp_last_of_run),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready),
      .mismatch_total   (mismatch_total),
      .pending_beats    (pending_beats)
   );

   // Watchdog: abandon a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("tty_output_postprocessor_unit test failed");
         $finish;
      end
   end

   // Receiver: honour a requested hold-off first, else stall at random when
   // idling is switched on. One assignment to rsp_ready per edge.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ready <= !(rsp_idles && $urandom_range(99) < 25);
         end
      end
   end

   // APB write: setup cycle, access cycle, then an idle cycle so that
   // back-to-back transfers never touch psel twice in one step.
   task automatic csr_write(input logic [2:0] idx, input logic [DataWidth-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // APB read; the checker compares prdata against its own register copy.
   task automatic csr_read(input logic [2:0] idx);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic read_all_registers();
      for (int k = RegPostEnable; k <= RegScreenCols; k++) csr_read(3'(k));
   endtask

   task automatic apply_config(input bit post, input bit crnl, input bit cr_nl,
                               input bit no_cr, input bit nl_col, input logic [15:0] cols);
      csr_write(RegPostEnable,  32'(post));
      csr_write(RegNlToCrnl,    32'(crnl));
      csr_write(RegCrToNl,      32'(cr_nl));
      csr_write(RegNoCrAtCol0,  32'(no_cr));
      csr_write(RegNlResetsCol, 32'(nl_col));
      csr_write(RegScreenCols,  32'(cols));
      read_all_registers();
   endtask

   // Flag value with junk in the unused upper bits.
   function automatic logic [DataWidth-1:0] flag_word(input bit f);
      return (DataWidth'($urandom()) & ~32'd1) | 32'(f);
   endfunction

   task automatic randomise_config();
      logic [15:0] cols;
      case ($urandom_range(5))
         0:       cols = 16'd0;
         1:       cols = 16'd1;
         2:       cols = 16'($urandom_range(12, 2));
         3:       cols = 16'd80;
         4:       cols = 16'hFFFF;
         default: cols = 16'($urandom_range(65535));
      endcase
      csr_write(RegPostEnable,  flag_word($urandom_range(9) != 0));
      csr_write(RegNlToCrnl,    flag_word($urandom_range(1)));
      csr_write(RegCrToNl,      flag_word($urandom_range(1)));
      csr_write(RegNoCrAtCol0,  flag_word($urandom_range(1)));
      csr_write(RegNlResetsCol, flag_word($urandom_range(1)));
      csr_write(RegScreenCols,  (DataWidth'($urandom()) & 32'hFFFF_0000) | 32'(cols));
      // now and then poke a spare slot; it must change nothing
      if ($urandom_range(2) == 0) csr_write($urandom_range(1) ? RegSpareLo : RegSpareHi, $urandom());
      read_all_registers();
   endtask

   // Offer one beat; valid stays high after acceptance unless the next call gaps.
   task automatic offer_byte(input logic [ByteWidth-1:0] b);
      while (req_idles && $urandom_range(99) < 25) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      do @(posedge clock); while (!req_ready);
   endtask

   // Drop valid, wait for every expected beat, then let the block go quiet.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_beats != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   function automatic logic [ByteWidth-1:0] ordinary_byte();
      logic [ByteWidth-1:0] b;
      do b = ByteWidth'($urandom_range(255)); while (b == ChNl || b == ChCr || b == ChBs);
      return b;
   endfunction

   // Bias towards the control bytes so every translation path is hit often.
   function automatic logic [ByteWidth-1:0] random_byte();
      int pick;
      pick = $urandom_range(99);
      if (pick < 15) return ChNl;
      if (pick < 30) return ChCr;
      if (pick < 40) return ChBs;
      return ByteWidth'($urandom_range(255));
   endfunction

   task automatic stream_ordinary(input int n);
      for (int i = 0; i < n; i++) offer_byte(ordinary_byte());
   endtask

   task automatic random_phase(input int n_items, input bit idles, input int hold);
      randomise_config();
      req_idles = idles;
      rsp_idles = idles;
      hold_left = hold;
      for (int i = 0; i < n_items; i++) offer_byte(random_byte());
      drain_results();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset values, then defaults: CR NL expansion, plain bytes, backspace at zero.
      req_idles = 1'b1;
      rsp_idles = 1'b1;
      read_all_registers();
      offer_byte(8'h41);
      offer_byte(8'h00);
      offer_byte(8'hFF);
      offer_byte(ChNl);
      offer_byte(ChBs);
      offer_byte(ChCr);
      drain_results();

      // Spare slots take all ones and must be ignored.
      csr_write(RegSpareLo, 32'hFFFF_FFFF);
      csr_write(RegSpareHi, 32'hFFFF_FFFF);
      read_all_registers();

      // Bare NL, CR becomes NL, NL clears column, width of one.
      apply_config(1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 16'd1);
      offer_byte(8'h7F);
      offer_byte(ChNl);
      offer_byte(ChCr);
      offer_byte(8'h55);
      offer_byte(ChBs);
      drain_results();

      // CR dropped at column zero, kept elsewhere; wrap at three.
      apply_config(1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 16'd3);
      offer_byte(ChCr);
      offer_byte(8'h41);
      offer_byte(8'h42);
      offer_byte(ChCr);
      offer_byte(ChCr);
      repeat (4) offer_byte(8'h41);
      offer_byte(ChNl);
      drain_results();

      // Translations off: control bytes pass through as themselves.
      apply_config(1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 16'hFFFF);
      offer_byte(ChNl);
      offer_byte(ChCr);
      offer_byte(ChBs);
      offer_byte(8'h80);
      drain_results();

      // Stretch with no idling: climb with no wrap, then shrink the width well
      // below the column so the next byte needs a true remainder.
      req_idles = 1'b0;
      rsp_idles = 1'b0;
      apply_config(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0);
      offer_byte(ChCr);
      stream_ordinary(40);
      drain_results();
      csr_write(RegScreenCols, 32'd7);
      offer_byte(ordinary_byte());
      drain_results();

      // Random phases; the fourth holds the receiver off so the block backs up.
      random_phase(60, 1'b0, 0);
      for (int p = 1; p < 10; p++) random_phase(60, 1'b1, (p == 3) ? 300 : 0);

      drain_results();
      if (mismatch_total == 0) begin
         $display("tty_output_postprocessor_unit test passed");
      end else begin
         $display("tty_output_postprocessor_unit test failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/ttyop_pkg.sv
hdl/ttyop_csr.sv
hdl/ttyop_rem.sv
hdl/ttyop_dpath.sv
hdl/ttyop_ctrl.sv
hdl/tty_output_postprocessor_unit.sv
tb/sv/ttyop_display_checker.sv
tb/sv/tb_top.sv
